// ===== design/aes128_pkg.sv =====
// ----------------------------------------------------------------------------
// aes128 package
// shared types, s-box tables and round helper functions for the aes-128 core
// ----------------------------------------------------------------------------
`default_nettype none

package aes128_pkg;

	localparam int unsigned ROUNDS_DEFAULT = 10;

	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

	typedef struct packed {
		logic        action;
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic        block_last;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic        result_last;
	} aes_out_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] ISBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// multiply by x in gf(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// one column of mix columns, forward or inverse
	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m3 [4];
		logic [7:0] o [4];
		for (int i = 0; i < 4; i++) begin
			a[i]  = c[31-8*i -: 8];
			a2[i] = xtime(a[i]);
			a4[i] = xtime(a2[i]);
			a8[i] = xtime(a4[i]);
			m3[i] = a2[i] ^ a[i];
		end
		for (int r = 0; r < 4; r++) begin
			if (!inv) begin
				o[r] = a2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
			end else begin
				// 14, 11, 13, 9
				o[r] = (a8[r] ^ a4[r] ^ a2[r])
					^ (a8[(r+1)%4] ^ a2[(r+1)%4] ^ a[(r+1)%4])
					^ (a8[(r+2)%4] ^ a4[(r+2)%4] ^ a[(r+2)%4])
					^ (a8[(r+3)%4] ^ a[(r+3)%4]);
			end
		end
		return {o[0], o[1], o[2], o[3]};
	endfunction

	// sub bytes then shift rows (forward) or inverse shift rows then inverse sub bytes
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [127:0] o;
		for (int i = 0; i < 16; i++) begin
			b[i] = s[127-8*i -: 8];
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (!inv) begin
					t[r+4*c] = SBOX[b[r+4*((c+r)%4)]];
				end else begin
					t[r+4*((c+r)%4)] = ISBOX[b[r+4*c]];
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			o[127-8*i -: 8] = t[i];
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
		end
		return o;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// next 128-bit round key from the previous one
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

`default_nettype wire

// ===== design/aes128_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// aes-128 block cipher core
// fully unrolled ecb encrypt / decrypt pipeline with an on-chip key schedule
// ----------------------------------------------------------------------------
// One item enters per cycle while the output is not stalled; each passes one
// stage per round (sub/shift, mix except in the last round, round key add)
// plus an input key-add stage and an output register. The round-key schedule
// is expanded by a sequencer, one round key per cycle, after reset and after
// every key write; while it runs no item is accepted. Configuration must be
// written only while the pipeline is empty; the core does not enforce this.
// A stall on the output freezes the whole pipeline, so nothing is lost.
`default_nettype none

module aes128_block_cipher_core
	import aes128_pkg::*;
#(
	parameter int unsigned ROUNDS = ROUNDS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire aes_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output aes_out_t         out_data,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int unsigned CW = $clog2(ROUNDS + 1);

	// key registers and expanded schedule (the initial key plus one 128-bit key per round)
	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] rk_q [ROUNDS+1];
	logic [7:0]   rcon_q;
	logic [CW-1:0] exp_cnt_q;
	logic          exp_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			exp_busy_q <= 1'b1;
			exp_cnt_q  <= '0;
			rcon_q     <= 8'h01;
		end else if (cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW)) begin
			if (cfg_index == CFG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end else begin
				key_low_q <= cfg_data;
			end
			exp_busy_q <= 1'b1;
			exp_cnt_q  <= '0;
			rcon_q     <= 8'h01;
		end else if (exp_busy_q) begin
			exp_cnt_q <= exp_cnt_q + 1'b1;
			if (exp_cnt_q != '0) begin
				rcon_q <= xtime(rcon_q);
			end
			if (exp_cnt_q == CW'(ROUNDS)) begin
				exp_busy_q <= 1'b0;
			end
		end
	end

	// schedule sequencer: step 0 loads the key, later steps derive the next one
	always_ff @(posedge clk) begin
		if (exp_busy_q) begin
			for (int r = 0; r <= ROUNDS; r++) begin
				if (exp_cnt_q == CW'(r)) begin
					if (r == 0) begin
						rk_q[r] <= {key_high_q, key_low_q};
					end else begin
						rk_q[r] <= next_key(rk_q[r-1], rcon_q);
					end
				end
			end
		end
	end

	// pipeline: stage 0 is the first key add, stages 1..ROUNDS one round each
	logic         v_s   [ROUNDS+1];
	logic [127:0] st_s  [ROUNDS+1];
	logic         dec_s [ROUNDS+1];
	logic         last_s[ROUNDS+1];
	logic         advance;

	// a stalled output freezes every stage
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance && !exp_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ROUNDS; i++) begin
				v_s[i] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (advance) begin
			v_s[0] <= in_valid && !exp_busy_q;
			for (int i = 1; i <= ROUNDS; i++) begin
				v_s[i] <= v_s[i-1];
			end
			out_valid <= v_s[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s[0]   <= {in_data.block_high, in_data.block_low}
				^ (in_data.action == ACT_DECRYPT ? rk_q[ROUNDS] : rk_q[0]);
			dec_s[0]  <= in_data.action;
			last_s[0] <= in_data.block_last;
			for (int i = 1; i <= ROUNDS; i++) begin
				dec_s[i]  <= dec_s[i-1];
				last_s[i] <= last_s[i-1];
				if (dec_s[i-1] == ACT_DECRYPT) begin
					// inverse round: inv shift/sub, key add, inv mix except last
					if (i == ROUNDS) begin
						st_s[i] <= sub_shift(st_s[i-1], 1'b1) ^ rk_q[ROUNDS-i];
					end else begin
						st_s[i] <= mix_all(sub_shift(st_s[i-1], 1'b1) ^ rk_q[ROUNDS-i],
							1'b1);
					end
				end else begin
					if (i == ROUNDS) begin
						st_s[i] <= sub_shift(st_s[i-1], 1'b0) ^ rk_q[i];
					end else begin
						st_s[i] <= mix_all(sub_shift(st_s[i-1], 1'b0), 1'b0) ^ rk_q[i];
					end
				end
			end
			out_data.result_high <= st_s[ROUNDS][127:64];
			out_data.result_low  <= st_s[ROUNDS][63:0];
			out_data.result_last <= last_s[ROUNDS];
		end
	end

endmodule

`default_nettype wire

// ===== design/aes128_checker.sv =====
// ----------------------------------------------------------------------------
// aes128 port checker
// handshake and key-write checks on the core ports
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [128:0] out_data,
	input wire logic        cfg_we
);

	// output item holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	// a stalled output blocks the input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// key writes restart the schedule, so input is closed next cycle
	a_cfg_closes: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input open right after key write");

endmodule

bind aes128_block_cipher_core aes128_checker u_aes128_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_we    (cfg_we && (cfg_index == aes128_pkg::CFG_KEY_HIGH
		|| cfg_index == aes128_pkg::CFG_KEY_LOW))
);

`default_nettype wire
